// ----- src/rmf_pkg.sv -----
// shared constants and types of the rgb 3x3 median filter
// no dependencies; used by every module of the block but rmf_ram
package rmf_pkg;

    localparam int CHAN_W          = 8;
    localparam int PIX_W           = 3 * CHAN_W;
    localparam int MAX_LINE_DEF    = 2048;

    localparam int LINE_LENGTH_W   = 12;
    localparam int LINE_COUNT_W    = 16;
    localparam int LINE_LENGTH_RST = 480;
    localparam int LINE_COUNT_RST  = 640;

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;

    // one channel of a 3x3 window, index column * 3 + row
    typedef logic [8:0][CHAN_W-1:0] chan_win_t;

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } result_t;

endpackage

// ----- src/rmf_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rmf_lane.sv -----
// one channel lane: median of nine values in three registered stages
// depends on rmf_pkg
module rmf_lane (
    input  logic                      aclk,
    input  logic                      en,
    input  rmf_pkg::chan_win_t        win,
    output logic [rmf_pkg::CHAN_W-1:0] median
);

    localparam int W = rmf_pkg::CHAN_W;

    function automatic logic [W-1:0] min2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [W-1:0] max2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [W-1:0] med3(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [2:0][W-1:0] mn_reg, md_reg, mx_reg;
    logic [W-1:0]      lo_reg, mi_reg, hi_reg;
    logic [W-1:0]      med_reg;

    // column sort, then max of mins, median of medians, min of maxes, then their median
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                mn_reg[c] <= min2(min2(win[c*3], win[c*3+1]), win[c*3+2]);
                md_reg[c] <= med3(win[c*3], win[c*3+1], win[c*3+2]);
                mx_reg[c] <= max2(max2(win[c*3], win[c*3+1]), win[c*3+2]);
            end
            lo_reg  <= max2(max2(mn_reg[0], mn_reg[1]), mn_reg[2]);
            mi_reg  <= med3(md_reg[0], md_reg[1], md_reg[2]);
            hi_reg  <= min2(min2(mx_reg[0], mx_reg[1]), mx_reg[2]);
            med_reg <= med3(lo_reg, mi_reg, hi_reg);
        end
    end

    assign median = med_reg;

endmodule

// ----- src/rmf_merge.sv -----
// merging stage: packs the three lane medians into the output stream
// with a skid register; depends on rmf_pkg
module rmf_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rmf_pkg::result_t            in_res,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rmf_pkg::PIX_W-1:0]   m_tdata,
    output logic                        m_tlast
);

    rmf_pkg::result_t out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : in_res;
        end else if (!skid_valid_reg) begin
            skid_reg <= in_res;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red};
    assign m_tlast  = out_reg.last;

endmodule

// ----- src/rgb_median_3x3_filter.sv -----
// rgb 3x3 median filter, top level: position counters, line store, window
// depends on rmf_pkg, rmf_ram, rmf_lane, rmf_merge
// throughput: one pixel transaction per cycle while the output is not stalled, set by
// one line store read and one write per cycle; path: a result passes the b stage, the c
// window register, the lane stages and the merge output register after the transaction that completes its window
// reset: synchronous active low; registers to 480 and 640, counters and window
// cleared; the line store is not cleared and needs no clearing pass
module rgb_median_3x3_filter #(
    parameter int MAX_LINE = rmf_pkg::MAX_LINE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rmf_pkg::PIX_W-1:0]       s_tdata,  // red_in, green_in, blue_in
    input  logic                            s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rmf_pkg::PIX_W-1:0]       m_tdata,  // red_median, green_median, blue_median
    output logic                            m_tlast,  // frame_last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int LEN_W  = $clog2(MAX_LINE + 1);
    localparam int CNT_W  = rmf_pkg::LINE_COUNT_W;
    localparam int PW     = rmf_pkg::PIX_W;
    localparam int CW     = rmf_pkg::CHAN_W;

    typedef struct packed {
        logic produce;
        logic last;
        logic line1;
        logic line2;
        logic c0_ok;
        logic c2_ok;
        logic r0_ok;
        logic r2_ok;
    } item_ctrl_t;

    typedef logic [8:0][PW-1:0] win_t;

    function automatic logic [LEN_W-1:0] eff_len(input logic [rmf_pkg::LINE_LENGTH_W-1:0] raw);
        logic [31:0] v;
        v = 32'(raw);
        if (raw == '0) begin
            v = 32'd1;
        end else if (v > 32'(MAX_LINE)) begin
            v = 32'(MAX_LINE);
        end
        return LEN_W'(v);
    endfunction

    function automatic logic [CNT_W-1:0] eff_cnt(input logic [CNT_W-1:0] raw);
        return (raw == '0) ? CNT_W'(1) : raw;
    endfunction

    logic             adv, accept, cfg_fire, cfg_restart, b_fire;
    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W:0]   in_line_reg;
    logic [ADDR_W-1:0] in_pix_reg;
    logic [CNT_W-1:0] out_line_reg;
    logic [ADDR_W-1:0] out_pix_reg;

    logic             in_pix_end, out_pix_end, ox_end;
    item_ctrl_t       a_ctrl;
    logic [PW-1:0]    a_pix;

    logic             b_valid_reg;
    item_ctrl_t       b_ctrl_reg;
    logic [PW-1:0]    b_pix_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic             byp_valid_reg;
    logic [2*PW-1:0]  byp_data_reg;
    logic [2*PW-1:0]  ram_rdata, ram_wdata, prev_word;
    logic [PW-1:0]    prev1, prev2;

    win_t             win_reg, win_new, win_masked, c_win_reg;
    logic             c_valid_reg, c_last_reg;
    logic [2:0]       vld_pipe_reg, last_pipe_reg;

    rmf_pkg::chan_win_t      lane_win [3];
    logic [2:0][CW-1:0]      lane_med;
    rmf_pkg::result_t        res;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_fire && ((cfg_index == rmf_pkg::CFG_LINE_LENGTH)
                                   || (cfg_index == rmf_pkg::CFG_LINE_COUNT));
    assign s_tready    = adv;
    assign accept      = s_tvalid && s_tready;
    assign b_fire      = b_valid_reg && adv;

    // item control, from the position counters
    always_comb begin
        in_pix_end  = LEN_W'(LEN_W'(in_pix_reg) + LEN_W'(1)) >= len_reg;
        out_pix_end = LEN_W'(LEN_W'(out_pix_reg) + LEN_W'(1)) >= len_reg;
        ox_end      = ({1'b0, out_line_reg} + (CNT_W+1)'(1)) >= {1'b0, cnt_reg};
        a_ctrl.produce = (in_line_reg >= (CNT_W+1)'(2))
                      || ((in_line_reg == (CNT_W+1)'(1)) && (in_pix_reg != '0));
        a_ctrl.last    = a_ctrl.produce && ox_end && out_pix_end;
        a_ctrl.line1   = in_line_reg != '0;
        a_ctrl.line2   = in_line_reg >= (CNT_W+1)'(2);
        a_ctrl.c0_ok   = out_line_reg != '0;
        a_ctrl.c2_ok   = !ox_end;
        a_ctrl.r0_ok   = out_pix_reg != '0;
        a_ctrl.r2_ok   = !out_pix_end;
        a_pix = (!s_tuser && (in_line_reg < {1'b0, cnt_reg})) ? s_tdata : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= eff_len(rmf_pkg::LINE_LENGTH_W'(rmf_pkg::LINE_LENGTH_RST));
            cnt_reg      <= CNT_W'(rmf_pkg::LINE_COUNT_RST);
            in_line_reg  <= '0;
            in_pix_reg   <= '0;
            out_line_reg <= '0;
            out_pix_reg  <= '0;
        end else if (cfg_restart) begin
            case (cfg_index)
                rmf_pkg::CFG_LINE_LENGTH: begin
                    len_reg      <= eff_len(cfg_data[rmf_pkg::LINE_LENGTH_W-1:0]);
                    in_line_reg  <= '0;
                    in_pix_reg   <= '0;
                    out_line_reg <= '0;
                    out_pix_reg  <= '0;
                end
                rmf_pkg::CFG_LINE_COUNT: begin
                    cnt_reg      <= eff_cnt(cfg_data[CNT_W-1:0]);
                    in_line_reg  <= '0;
                    in_pix_reg   <= '0;
                    out_line_reg <= '0;
                    out_pix_reg  <= '0;
                end
                default: ;
            endcase
        end else if (accept) begin
            if (a_ctrl.last) begin
                in_line_reg  <= '0;
                in_pix_reg   <= '0;
                out_line_reg <= '0;
                out_pix_reg  <= '0;
            end else begin
                if (in_pix_end) begin
                    in_pix_reg  <= '0;
                    in_line_reg <= in_line_reg + (CNT_W+1)'(1);
                end else begin
                    in_pix_reg <= in_pix_reg + ADDR_W'(1);
                end
                if (a_ctrl.produce) begin
                    if (out_pix_end) begin
                        out_pix_reg  <= '0;
                        out_line_reg <= out_line_reg + CNT_W'(1);
                    end else begin
                        out_pix_reg <= out_pix_reg + ADDR_W'(1);
                    end
                end
            end
        end
    end

    rmf_ram #(
        .WIDTH(2 * PW),
        .DEPTH(MAX_LINE)
    ) u_line_store (
        .aclk (aclk),
        .we   (b_fire),
        .waddr(b_addr_reg),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(in_pix_reg),
        .rdata(ram_rdata)
    );

    // window update with the line store word of this position
    always_comb begin
        prev_word = byp_valid_reg ? byp_data_reg : ram_rdata;
        prev1     = b_ctrl_reg.line1 ? prev_word[PW-1:0] : '0;
        prev2     = b_ctrl_reg.line2 ? prev_word[2*PW-1:PW] : '0;
        ram_wdata = {prev1, b_pix_reg};
        for (int c = 0; c < 3; c++) begin
            win_new[c*3]   = win_reg[c*3+1];
            win_new[c*3+1] = win_reg[c*3+2];
        end
        win_new[2] = prev2;
        win_new[5] = prev1;
        win_new[8] = b_pix_reg;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if ((c == 0 && !b_ctrl_reg.c0_ok) || (c == 2 && !b_ctrl_reg.c2_ok)
                    || (r == 0 && !b_ctrl_reg.r0_ok) || (r == 2 && !b_ctrl_reg.r2_ok)) begin
                    win_masked[c*3+r] = '0;
                end else begin
                    win_masked[c*3+r] = win_new[c*3+r];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
            c_valid_reg   <= 1'b0;
            vld_pipe_reg  <= '0;
            win_reg       <= '0;
        end else begin
            if (cfg_restart) begin
                win_reg <= '0;
            end else if (b_fire) begin
                win_reg <= b_ctrl_reg.last ? '0 : win_new;
            end
            if (accept) begin
                byp_valid_reg <= b_fire && (b_addr_reg == in_pix_reg);
            end
            if (adv) begin
                b_valid_reg  <= accept;
                c_valid_reg  <= b_valid_reg && b_ctrl_reg.produce;
                vld_pipe_reg <= {vld_pipe_reg[1:0], c_valid_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_ctrl_reg   <= a_ctrl;
            b_pix_reg    <= a_pix;
            b_addr_reg   <= in_pix_reg;
            byp_data_reg <= ram_wdata;
        end
        if (adv) begin
            c_win_reg     <= win_masked;
            c_last_reg    <= b_ctrl_reg.last;
            last_pipe_reg <= {last_pipe_reg[1:0], c_last_reg};
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        always_comb begin
            for (int i = 0; i < 9; i++) begin
                lane_win[ch][i] = c_win_reg[i][ch*CW +: CW];
            end
        end

        rmf_lane u_lane (
            .aclk  (aclk),
            .en    (adv),
            .win   (lane_win[ch]),
            .median(lane_med[ch])
        );
    end

    assign res.last  = last_pipe_reg[2];
    assign res.red   = lane_med[0];
    assign res.green = lane_med[1];
    assign res.blue  = lane_med[2];

    rmf_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(vld_pipe_reg[2]),
        .in_ready(adv),
        .in_res  (res),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
